@@ sv/afd_pkg.sv @@
// Package for the accelerometer response deframer.
// Holds the item types, frame constants and the start-byte decode.
// No dependencies.
package afd_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned AXIS_W    = 24;
    localparam int unsigned SCALE_W   = 16;

    localparam logic [POS_W-1:0] POS_HDR0      = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1      = 4'd1;
    localparam logic [POS_W-1:0] POS_AXIS_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(FRAME_LEN);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd12519;

    localparam logic [7:0] START_12BIT = 8'h2A;
    localparam logic [7:0] START_16BIT = 8'h23;
    localparam logic [7:0] START_24BIT = 8'h24;

    typedef enum logic [1:0] {
        PREC_UNKNOWN = 2'd0,
        PREC_12BIT   = 2'd1,
        PREC_16BIT   = 2'd2,
        PREC_24BIT   = 2'd3
    } t_precision;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_of_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_accel;
        logic signed [AXIS_W-1:0] y_accel;
        logic signed [AXIS_W-1:0] z_accel;
        logic                     frame_ok;
        logic [1:0]               precision_code;
    } t_out_item;

    function automatic t_precision precision_of(input logic [7:0] b);
        t_precision p;
        case (b)
            START_12BIT: p = PREC_12BIT;
            START_16BIT: p = PREC_16BIT;
            START_24BIT: p = PREC_24BIT;
            default:     p = PREC_UNKNOWN;
        endcase
        return p;
    endfunction

endpackage

@@ sv/accel_frame_deframer_core.sv @@
// Accelerometer response deframer: collects nine bytes and emits scaled axes or the last good values.
// Depends on afd_pkg for item types, constants and the start-byte decode.
// An accepted byte is first registered in the input register; a ninth byte then loads the result register.
// Throughput: one byte per cycle; a ninth byte waits only while the last result is held.
// The result of a frame is loaded when its ninth byte fires from the input register.
// Reset is synchronous and active low; it clears position, stores and precision.
module accel_frame_deframer_core
    import afd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    logic                     r_in_valid;
    t_in_item                 r_in;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;
    logic [7:0]               r_hdr [2];
    logic [15:0]              r_raw [NUM_AXES];
    logic signed [AXIS_W-1:0] r_last [NUM_AXES];
    t_precision               r_prec;
    logic [SCALE_W-1:0]       r_scale;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [POS_W-1:0]         w_pos;
    logic [POS_W-1:0]         w_axis_off;
    logic [1:0]               w_axis;
    logic                     w_end;
    logic                     w_fire;
    logic                     w_ok;
    t_precision               w_hdr_prec;
    logic signed [AXIS_W-1:0] w_scaled [NUM_AXES];
    logic signed [AXIS_W-1:0] w_res [NUM_AXES];

    always_comb begin
        if (r_in.first_of_frame || r_pos >= POS_LIMIT) begin
            w_pos = POS_HDR0;
        end else begin
            w_pos = r_pos;
        end
        w_axis_off = w_pos - 4'd2;
        w_axis     = w_axis_off[2:1];
        w_end      = (w_pos == POS_LAST);
        w_fire     = r_in_valid && (!w_end || !r_out_valid || i_out_ready);
        o_in_ready = !r_in_valid || w_fire;
        n_pos      = w_end ? POS_HDR0 : w_pos + 4'd1;
        w_hdr_prec = precision_of(r_hdr[0]);
        w_ok       = (r_hdr[0] == r_hdr[1]) && (w_hdr_prec != PREC_UNKNOWN);
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        logic signed [15:0] w_d;
        logic signed [32:0] w_prod;
        logic signed [33:0] w_sum;
        logic signed [25:0] w_q;

        always_comb begin
            w_d    = $signed({~r_raw[g][15], r_raw[g][14:0]});
            w_prod = w_d * $signed({1'b0, r_scale});
            w_sum  = 34'(w_prod) + 34'sd128;
            w_q    = w_sum[33:8];
            if (w_q > 26'sd8388607) begin
                w_scaled[g] = 24'sh7FFFFF;
            end else if (w_q < -26'sd8388608) begin
                w_scaled[g] = 24'sh800000;
            end else begin
                w_scaled[g] = w_q[23:0];
            end
            w_res[g] = w_ok ? w_scaled[g] : r_last[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= POS_HDR0;
            r_prec      <= PREC_UNKNOWN;
            r_scale     <= SCALE_RESET;
            r_out_valid <= 1'b0;
            r_hdr[0]    <= '0;
            r_hdr[1]    <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_raw[i]  <= '0;
                r_last[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in       <= i_in_item;
            end
            if (w_fire && w_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_pos <= n_pos;
                if (w_pos <= POS_HDR1) begin
                    r_hdr[w_pos[0]] <= r_in.rx_byte;
                end else if (w_pos <= POS_AXIS_LAST) begin
                    if (!w_axis_off[0]) begin
                        r_raw[w_axis] <= {r_in.rx_byte, 8'h00};
                    end else begin
                        r_raw[w_axis] <= {r_raw[w_axis][15:8], r_in.rx_byte};
                    end
                end
                if (w_end) begin
                    if (w_ok) begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                            r_last[i] <= w_scaled[i];
                        end
                        if (r_prec == PREC_UNKNOWN) begin
                            r_prec <= w_hdr_prec;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_end) begin
            r_out.x_accel        <= w_res[0];
            r_out.y_accel        <= w_res[1];
            r_out.z_accel        <= w_res[2];
            r_out.frame_ok       <= w_ok;
            r_out.precision_code <= (w_ok && r_prec == PREC_UNKNOWN) ? w_hdr_prec : r_prec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position beyond the frame");

    a_prec_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prec != PREC_UNKNOWN |=> r_prec == $past(r_prec))
        else $error("latched precision changed");

    a_ok_has_prec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_ok |-> o_out_item.precision_code != PREC_UNKNOWN)
        else $error("good frame reported without a precision");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && w_end) |=> $stable(r_last[0]) && $stable(r_last[1]) && $stable(r_last[2]))
        else $error("last good values changed outside a frame end");

endmodule
